// ----- hdl/tlvv_pkg.sv -----
// Shared types, codes and defaults for the TLV message validator.
`timescale 1ns / 1ps

package tlvv_pkg;

    // Default parameter values.
    localparam int DEF_NUM_TYPES         = 16;
    localparam int DEF_MAX_MESSAGE_BYTES = 8388608;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TYPE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_POLICY_TABLE = 2'd1;
    localparam logic [1:0] CFG_FAIL_UNKNOWN = 2'd2;

    // Bit positions in the payload flag word.
    localparam int FLAG_EARLY_ZERO = 0;
    localparam int FLAG_LAST_ZERO  = 1;
    localparam int FLAG_BOOL_BAD   = 2;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    // Attribute kinds held in the low three bits of a policy nibble.
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_BOOL = 3'd1,
        KIND_I32  = 3'd2,
        KIND_U32  = 3'd3,
        KIND_I64  = 3'd4,
        KIND_U64  = 3'd5,
        KIND_STR  = 3'd6,
        KIND_MEM  = 3'd7
    } kind_t;

    // Configuration register file.
    typedef struct packed {
        logic [4:0]  type_count;
        logic [63:0] policy_table;
        logic        fail_unknown;
    } cfg_t;

    // Outcome of checking one finished attribute.
    typedef struct packed {
        status_t err;
        logic    accept;
    } chk_t;

endpackage

// ----- hdl/tlv_message_validator.sv -----
// Top level: streaming TLV attribute parser and policy validator.
// All per-byte work is one pass of state update logic; each result is registered.
// Throughput: one byte item per cycle while s_ready is high.
// s_ready drops only while both the output register and the skid register hold results.
// Reset is synchronous and active low; it clears message state, configuration and results.
`timescale 1ns / 1ps

module tlv_message_validator #(
    parameter int NUM_TYPES         = tlvv_pkg::DEF_NUM_TYPES,
    parameter int MAX_MESSAGE_BYTES = tlvv_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_attr_count,
    output logic [15:0] m_present_mask
);
    import tlvv_pkg::*;

    localparam int TOT_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int HW    = $clog2(NUM_TYPES + 1);
    localparam logic [TOT_W-1:0] MaxBytes = TOT_W'(MAX_MESSAGE_BYTES);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PAD     = 2'd2
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  attr_count;
        logic [15:0] present_mask;
    } res_t;

    // State registers.
    phase_t               phase_reg, phase_a, phase_next;
    logic [1:0]           hdr_idx_reg, hdr_a, hdr_next;
    logic [7:0]           cur_type_reg, type_a, type_next;
    logic [23:0]          pay_len_reg, len_a, len_next;
    logic [23:0]          pay_seen_reg, seen_a, seen_next;
    logic [2:0]           pay_flags_reg, flags_a, flags_next;
    logic [TOT_W-1:0]     total_reg, total_a, total_next;
    logic [NUM_TYPES-1:0] seen_mask_reg, seen_mask_next;
    logic [HW-1:0]        highest_reg, highest_next;
    status_t              err_reg, err_next;
    cfg_t                 cfg_reg;
    logic                 out_valid_reg, skid_valid_reg;
    res_t                 out_reg, skid_reg;

    logic        s_xfer;
    logic        take;
    logic        fin;
    logic [23:0] seen_inc;
    logic [1:0]  pad;
    logic [4:0]  type_plus1;
    logic        res_valid;
    res_t        res;
    chk_t        chk;

    assign s_xfer = s_valid && s_ready;

    // Byte intake: byte counter, header assembly, payload scan and padding skip.
    always_comb begin
        phase_a  = phase_reg;
        hdr_a    = hdr_idx_reg;
        type_a   = cur_type_reg;
        len_a    = pay_len_reg;
        seen_a   = pay_seen_reg;
        flags_a  = pay_flags_reg;
        fin      = 1'b0;
        seen_inc = pay_seen_reg + 24'd1;

        total_a = total_reg;
        if (s_xfer && s_byte_present && (total_reg < MaxBytes)) begin
            total_a = total_reg + TOT_W'(1);
        end
        take = s_xfer && s_byte_present && (total_a < MaxBytes) && (err_reg == STATUS_OK);

        if (take) begin
            unique case (phase_reg)
                PH_PAYLOAD: begin
                    if (s_data_byte == 8'd0) begin
                        if (seen_inc == pay_len_reg) begin
                            flags_a[FLAG_LAST_ZERO] = 1'b1;
                        end else begin
                            flags_a[FLAG_EARLY_ZERO] = 1'b1;
                        end
                    end
                    if ((pay_seen_reg == 24'd0) && (s_data_byte > 8'd1)) begin
                        flags_a[FLAG_BOOL_BAD] = 1'b1;
                    end
                    seen_a = seen_inc;
                    fin    = seen_inc >= pay_len_reg;
                end
                PH_PAD: begin
                    hdr_a = hdr_idx_reg - 2'd1;
                    if (hdr_a == 2'd0) begin
                        phase_a = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    unique case (hdr_idx_reg)
                        2'd0: begin
                            type_a  = s_data_byte;
                            len_a   = 24'd0;
                            seen_a  = 24'd0;
                            flags_a = 3'd0;
                            hdr_a   = 2'd1;
                        end
                        2'd1: begin
                            len_a = {16'h0000, s_data_byte};
                            hdr_a = 2'd2;
                        end
                        2'd2: begin
                            len_a = {8'h00, s_data_byte, pay_len_reg[7:0]};
                            hdr_a = 2'd3;
                        end
                        2'd3: begin
                            len_a   = {s_data_byte, pay_len_reg[15:0]};
                            hdr_a   = 2'd0;
                            phase_a = PH_PAYLOAD;
                            fin     = len_a == 24'd0;
                        end
                    endcase
                end
                default: phase_a = PH_HEADER;
            endcase
        end
    end

    // Policy check on the attribute that completes in this transfer.
    tlvv_attr_check #(
        .NUM_TYPES(NUM_TYPES)
    ) u_attr_check (
        .cfg        (cfg_reg),
        .attr_type  (cur_type_reg),
        .attr_length(len_a),
        .attr_flags (flags_a),
        .seen_mask  (seen_mask_reg),
        .chk        (chk)
    );

    // Attribute completion, result formation and message clear.
    always_comb begin
        phase_next     = phase_a;
        hdr_next       = hdr_a;
        type_next      = type_a;
        len_next       = len_a;
        seen_next      = seen_a;
        flags_next     = flags_a;
        total_next     = total_a;
        seen_mask_next = seen_mask_reg;
        highest_next   = highest_reg;
        err_next       = err_reg;
        type_plus1     = {1'b0, cur_type_reg[3:0]} + 5'd1;
        pad            = 2'd0 - len_a[1:0];

        if (fin) begin
            if (chk.err != STATUS_OK) begin
                err_next = chk.err;
            end else if (chk.accept) begin
                seen_mask_next = seen_mask_reg | (NUM_TYPES'(1) << cur_type_reg[3:0]);
                if (type_plus1 > 5'(highest_reg)) begin
                    highest_next = HW'(type_plus1);
                end
            end
            if (pad != 2'd0) begin
                phase_next = PH_PAD;
                hdr_next   = pad;
            end else begin
                phase_next = PH_HEADER;
                hdr_next   = 2'd0;
            end
        end

        res_valid = s_xfer && s_message_end;
        priority if (total_a >= MaxBytes) begin
            res.status = STATUS_INVALID;
        end else if (err_next != STATUS_OK) begin
            res.status = err_next;
        end else if ((phase_next == PH_PAYLOAD)
                     || ((phase_next == PH_HEADER) && (hdr_next != 2'd0))) begin
            res.status = STATUS_INVALID;
        end else begin
            res.status = STATUS_OK;
        end
        res.attr_count   = (res.status == STATUS_OK) ? 5'(highest_next) : 5'd0;
        res.present_mask = (res.status == STATUS_OK) ? 16'(seen_mask_next) : 16'd0;

        if (res_valid) begin
            phase_next     = PH_HEADER;
            hdr_next       = 2'd0;
            type_next      = 8'd0;
            len_next       = 24'd0;
            seen_next      = 24'd0;
            flags_next     = 3'd0;
            total_next     = '0;
            seen_mask_next = '0;
            highest_next   = '0;
            err_next       = STATUS_OK;
        end
    end

    // State, configuration and the two-deep result buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_idx_reg    <= 2'd0;
            cur_type_reg   <= 8'd0;
            pay_len_reg    <= 24'd0;
            pay_seen_reg   <= 24'd0;
            pay_flags_reg  <= 3'd0;
            total_reg      <= '0;
            seen_mask_reg  <= '0;
            highest_reg    <= '0;
            err_reg        <= STATUS_OK;
            cfg_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end else begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_next;
            cur_type_reg  <= type_next;
            pay_len_reg   <= len_next;
            pay_seen_reg  <= seen_next;
            pay_flags_reg <= flags_next;
            total_reg     <= total_next;
            seen_mask_reg <= seen_mask_next;
            highest_reg   <= highest_next;
            err_reg       <= err_next;

            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_TYPE_COUNT:   cfg_reg.type_count   <= cfg_wr_data[4:0];
                    CFG_POLICY_TABLE: cfg_reg.policy_table <= cfg_wr_data;
                    CFG_FAIL_UNKNOWN: cfg_reg.fail_unknown <= cfg_wr_data[0];
                    default: ;
                endcase
            end

            // A result lands in the output register when it is free, else in the skid.
            if (out_valid_reg && m_ready) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else if (res_valid) begin
                    out_reg <= res;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (res_valid) begin
                if (!out_valid_reg) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign s_ready        = !skid_valid_reg;
    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_attr_count   = out_reg.attr_count;
    assign m_present_mask = out_reg.present_mask;

endmodule

// ----- hdl/tlvv_attr_check.sv -----
// Policy check applied to one attribute once its payload is complete.
`timescale 1ns / 1ps

module tlvv_attr_check #(
    parameter int NUM_TYPES = tlvv_pkg::DEF_NUM_TYPES
) (
    input  tlvv_pkg::cfg_t       cfg,
    input  logic [7:0]           attr_type,
    input  logic [23:0]          attr_length,
    input  logic [2:0]           attr_flags,
    input  logic [NUM_TYPES-1:0] seen_mask,
    output tlvv_pkg::chk_t       chk
);
    import tlvv_pkg::*;

    localparam logic [4:0] NumTypesW = 5'(NUM_TYPES);

    logic [4:0]  eff_count;
    logic        known;
    logic [3:0]  nib;
    kind_t       kind;
    logic [15:0] seen_ext;
    logic        bad;
    logic        none_kind;
    status_t     unknown_err;

    // Type lookup, repeat check and kind-specific length and content checks.
    always_comb begin
        eff_count   = (cfg.type_count > NumTypesW) ? NumTypesW : cfg.type_count;
        known       = attr_type < {3'b000, eff_count};
        nib         = cfg.policy_table[{attr_type[3:0], 2'b00} +: 4];
        kind        = kind_t'(nib[2:0]);
        seen_ext    = 16'(seen_mask);
        unknown_err = cfg.fail_unknown ? STATUS_UNKNOWN : STATUS_OK;
        bad         = 1'b0;
        none_kind   = 1'b0;

        unique case (kind)
            KIND_NONE: none_kind = 1'b1;
            KIND_BOOL: bad = (attr_length != 24'd1) || attr_flags[FLAG_BOOL_BAD];
            KIND_I32, KIND_U32: bad = attr_length != 24'd4;
            KIND_I64, KIND_U64: bad = attr_length != 24'd8;
            KIND_STR: bad = (attr_length == 24'd0) || attr_flags[FLAG_EARLY_ZERO]
                            || !attr_flags[FLAG_LAST_ZERO];
            KIND_MEM: bad = 1'b0;
        endcase

        chk.err    = STATUS_OK;
        chk.accept = 1'b0;
        priority if (!known) begin
            chk.err = unknown_err;
        end else if (seen_ext[attr_type[3:0]] && !nib[3]) begin
            chk.err = STATUS_INVALID;
        end else if (none_kind) begin
            chk.err = unknown_err;
        end else if (bad) begin
            chk.err = STATUS_INVALID;
        end else begin
            chk.accept = 1'b1;
        end
    end

endmodule

// ----- hdl/tlvv_checker.sv -----
// Port-level assertions for the TLV message validator and their bind.
`timescale 1ns / 1ps

module tlvv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_message_end,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [4:0]  m_attr_count,
    input logic [15:0] m_present_mask
);
    import tlvv_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_attr_count) && $stable(m_present_mask))
        else $error("result changed while stalled");

    // Every end-marked transfer leaves a result waiting in the next cycle.
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_message_end |=> m_valid)
        else $error("no result after end of message");

    // Error results carry no count and no mask.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> (m_attr_count == 5'd0)
            && (m_present_mask == 16'd0))
        else $error("error result with nonzero fields");

    // The attribute count points at the highest type present in the mask.
    a_count_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_attr_count != 5'd0) |->
            ((m_present_mask >> (m_attr_count - 5'd1)) == 16'd1))
        else $error("attribute count does not match presence mask");

endmodule

bind tlv_message_validator tlvv_checker u_tlvv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_message_end (s_message_end),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_attr_count  (m_attr_count),
    .m_present_mask(m_present_mask)
);
